// ----- rtl/irc_pkg.sv -----
`default_nettype none

package irc_pkg;

	// Longest byte run one input byte can cause, and the bits to count it
	localparam int MaxRun  = 11;
	localparam int RunW    = 4;
	// Byte slots in one escape or literal segment (six used at most)
	localparam int SegSlots = 8;
	localparam int SegW     = 3;
	// Command queue depth between the front and the back
	localparam int QDepth = 2;
	localparam int QPtrW  = 1;
	localparam int QCntW  = 2;

	// Control bytes of the chat text
	localparam logic [7:0] CtlBold      = 8'h02;
	localparam logic [7:0] CtlColour    = 8'h03;
	localparam logic [7:0] CtlBell      = 8'h07;
	localparam logic [7:0] CtlTab       = 8'h09;
	localparam logic [7:0] CtlNewline   = 8'h0A;
	localparam logic [7:0] CtlCr        = 8'h0D;
	localparam logic [7:0] CtlPlain     = 8'h0F;
	localparam logic [7:0] CtlReverse   = 8'h16;
	localparam logic [7:0] CtlUnderline = 8'h1F;
	localparam logic [7:0] ChSpace      = 8'h20;
	localparam logic [7:0] ChComma      = 8'h2C;
	localparam logic [7:0] ChZero       = 8'h30;
	localparam logic [7:0] ChNine       = 8'h39;

	// Escape sequence framing
	localparam logic [7:0] EscByte  = 8'h1B;
	localparam logic [7:0] SgrOpen  = 8'h5B;
	localparam logic [7:0] SgrClose = 8'h6D;
	localparam logic [3:0] AsciiDigitHi = 4'h3;

	// SGR attribute codes
	localparam logic [6:0] SgrNone      = 7'd0;
	localparam logic [6:0] SgrBoldOn    = 7'd1;
	localparam logic [6:0] SgrBoldOff   = 7'd22;
	localparam logic [6:0] SgrUlineOn   = 7'd4;
	localparam logic [6:0] SgrUlineOff  = 7'd24;
	localparam logic [6:0] SgrRevOn     = 7'd7;
	localparam logic [6:0] SgrRevOff    = 7'd27;
	localparam logic [6:0] SgrFgBase    = 7'd30;
	localparam logic [6:0] SgrBgBase    = 7'd40;
	localparam logic [6:0] SgrBrightAdd = 7'd50;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       message_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// One escape or literal piece of output
	typedef struct packed {
		logic [SegW:0]                len;
		logic [SegSlots-1:0][7:0]     b;
	} seg_t;

	// One run of output bytes, queued from the front to the back
	typedef struct packed {
		logic [RunW-1:0]              len;
		logic [MaxRun-1:0][7:0]       b;
	} cmd_t;

	function automatic logic [6:0] colour_value(input logic [3:0] idx);
		logic [6:0] v;
		case (idx)
			4'd0:  v = 7'd0;
			4'd1:  v = 7'd7;
			4'd2:  v = 7'd4;
			4'd3:  v = 7'd2;
			4'd4:  v = 7'd1;
			4'd5:  v = 7'd3;
			4'd6:  v = 7'd5;
			4'd7:  v = 7'd11;
			4'd8:  v = 7'd13;
			4'd9:  v = 7'd12;
			4'd10: v = 7'd6;
			4'd11: v = 7'd16;
			4'd12: v = 7'd14;
			4'd13: v = 7'd15;
			4'd14: v = 7'd10;
			default: v = 7'd7;
		endcase
		return v;
	endfunction

	// SGR code for a colour number and ground
	function automatic logic [6:0] colour_code(input logic [3:0] idx, input logic bg);
		logic [6:0] v;
		v = colour_value(idx);
		if (v > 7'd9) begin
			v = v + SgrBrightAdd;
		end
		v = v + (bg ? SgrBgBase : SgrFgBase);
		return v;
	endfunction

	function automatic logic [7:0] ascii_digit(input logic [3:0] d);
		return {AsciiDigitHi, d};
	endfunction

	// ESC [ code m, or ESC [ m when there is no code
	function automatic seg_t sgr_seg(input logic [6:0] code, input logic has_code);
		seg_t s;
		logic [6:0] rem;
		logic [14:0] prod;
		logic [3:0] tens;
		logic [6:0] tens7;
		logic [6:0] ones7;
		s = '0;
		s.b[0] = EscByte;
		s.b[1] = SgrOpen;
		rem = (code >= 7'd100) ? code - 7'd100 : code;
		// divide by ten through the reciprocal, exact below 100
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		tens7 = 7'(tens);
		ones7 = rem - ((tens7 << 3) + (tens7 << 1));
		if (!has_code) begin
			s.b[2] = SgrClose;
			s.len = 4'd3;
		end else if (code >= 7'd100) begin
			s.b[2] = ascii_digit(4'd1);
			s.b[3] = ascii_digit(tens);
			s.b[4] = ascii_digit(ones7[3:0]);
			s.b[5] = SgrClose;
			s.len = 4'd6;
		end else if (code >= 7'd10) begin
			s.b[2] = ascii_digit(tens);
			s.b[3] = ascii_digit(ones7[3:0]);
			s.b[4] = SgrClose;
			s.len = 4'd5;
		end else begin
			s.b[2] = ascii_digit(ones7[3:0]);
			s.b[3] = SgrClose;
			s.len = 4'd4;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/irc_format_to_ansi_escape.sv -----
// Chat formatting to ANSI terminal escape translator.
// Input channel text_valid/text_ready carries one text byte and a message-last
// flag per transfer. Output channel term_valid/term_ready carries one terminal
// byte per transfer, run_last marking the final byte caused by an input byte.
// cfg_wr_en writes cfg_wr_data into the registered bell filter bit.
// The front classifies each byte and updates the parse state in the cycle it
// is accepted, queuing the whole output run (0 to 11 bytes) into a two-entry
// command queue; input bytes that give no output leave nothing behind.
// The back streams one byte per cycle from the queue head into the output
// register while the receiver takes them; a run's first byte is registered
// in a queue entry, then in the output register. Throughput is one output
// byte per cycle, so plain text flows at one byte per cycle and an escape
// holds the back until it is sent; input stalls only while the queue is full.
// When the receiver stalls, the output register holds its byte and the queue
// fills, then text_ready drops.
// Reset clears the parse state, the attributes, the filter bit, the queue and
// the output valid.
`default_nettype none

module irc_format_to_ansi_escape (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               text_valid,
	output logic                    text_ready,
	input  wire irc_pkg::in_item_t  text,
	output logic                    term_valid,
	input  wire logic               term_ready,
	output irc_pkg::out_item_t      term,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data
);

	logic          q_push, q_full, q_pop, q_head_valid;
	irc_pkg::cmd_t q_cmd, q_head;

	irc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (text_valid),
		.in_item    (text),
		.in_ready   (text_ready),
		.cfg_we     (cfg_wr_en),
		.cfg_filter (cfg_wr_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	irc_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	irc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.out_valid  (term_valid),
		.out_ready  (term_ready),
		.out_item   (term)
	);

endmodule

`default_nettype wire

// ----- rtl/irc_front.sv -----
`default_nettype none

module irc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire irc_pkg::in_item_t in_item,
	output logic                   in_ready,
	input  wire logic              cfg_we,
	input  wire logic              cfg_filter,
	input  wire logic              q_full,
	output logic                   q_push,
	output irc_pkg::cmd_t          q_cmd
);

	typedef enum logic [1:0] {
		MODE_TEXT,
		MODE_CTRL,
		MODE_NUM
	} mode_t;

	mode_t      mode_q, mode_n;
	logic [1:0] dcount_q, dcount_n;
	logic [6:0] cnum_q, cnum_n;
	logic       bg_q, bg_n;
	logic       bold_q, bold_n;
	logic       uline_q, uline_n;
	logic       rev_q, rev_n;
	logic       filter_q;

	logic [7:0] c;
	logic       is_digit;
	logic       take;

	irc_pkg::seg_t pre_seg, body_seg, suf_seg, plain_seg;
	logic       p_bold, p_uline, p_rev, p_ctrl;
	logic       run_plain;
	logic [10:0] cnum_mul;

	assign c        = in_item.text_byte;
	assign is_digit = (c >= irc_pkg::ChZero) && (c <= irc_pkg::ChNine);
	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign cnum_mul = (11'(cnum_q) << 3) + (11'(cnum_q) << 1) + 11'(c[3:0]);

	// ordinary text handling against the current attributes
	always_comb begin
		plain_seg = '0;
		p_bold    = bold_q;
		p_uline   = uline_q;
		p_rev     = rev_q;
		p_ctrl    = 1'b0;
		case (c)
			irc_pkg::CtlColour: begin
				p_ctrl = 1'b1;
			end
			irc_pkg::CtlReverse: begin
				p_rev     = !rev_q;
				plain_seg = irc_pkg::sgr_seg(p_rev ? irc_pkg::SgrRevOn : irc_pkg::SgrRevOff, 1'b1);
			end
			irc_pkg::CtlUnderline: begin
				p_uline   = !uline_q;
				plain_seg = irc_pkg::sgr_seg(p_uline ? irc_pkg::SgrUlineOn
					: irc_pkg::SgrUlineOff, 1'b1);
			end
			irc_pkg::CtlBold: begin
				p_bold    = !bold_q;
				plain_seg = irc_pkg::sgr_seg(p_bold ? irc_pkg::SgrBoldOn : irc_pkg::SgrBoldOff, 1'b1);
			end
			irc_pkg::CtlBell: begin
				if (!filter_q) begin
					plain_seg.b[0] = c;
					plain_seg.len  = 4'd1;
				end
			end
			irc_pkg::CtlPlain: begin
				plain_seg = irc_pkg::sgr_seg(irc_pkg::SgrNone, 1'b0);
				p_bold    = 1'b0;
				p_uline   = 1'b0;
				p_rev     = 1'b0;
			end
			irc_pkg::CtlTab: begin
				plain_seg.b[0] = irc_pkg::ChSpace;
				plain_seg.len  = 4'd1;
			end
			irc_pkg::CtlNewline: begin
				plain_seg.b[0] = irc_pkg::CtlCr;
				plain_seg.b[1] = irc_pkg::CtlNewline;
				plain_seg.len  = 4'd2;
			end
			default: begin
				plain_seg.b[0] = c;
				plain_seg.len  = 4'd1;
			end
		endcase
	end

	// parse state step and the pieces of output it causes
	always_comb begin
		mode_n    = mode_q;
		dcount_n  = dcount_q;
		cnum_n    = cnum_q;
		bg_n      = bg_q;
		bold_n    = bold_q;
		uline_n   = uline_q;
		rev_n     = rev_q;
		pre_seg   = '0;
		body_seg  = '0;
		suf_seg   = '0;
		run_plain = 1'b0;
		case (mode_q)
			MODE_CTRL: begin
				if (is_digit) begin
					mode_n   = MODE_NUM;
					dcount_n = 2'd1;
					cnum_n   = 7'(c[3:0]);
					bg_n     = 1'b0;
				end else begin
					pre_seg   = irc_pkg::sgr_seg(irc_pkg::SgrNone, 1'b0);
					mode_n    = MODE_TEXT;
					run_plain = 1'b1;
				end
			end
			MODE_NUM: begin
				if (is_digit && dcount_q < 2'd2) begin
					cnum_n   = cnum_mul[6:0];
					dcount_n = dcount_q + 2'd1;
				end else begin
					if (dcount_q == 2'd0) begin
						pre_seg = irc_pkg::sgr_seg(irc_pkg::SgrNone, 1'b0);
					end else begin
						pre_seg = irc_pkg::sgr_seg(irc_pkg::colour_code(cnum_q[3:0], bg_q), 1'b1);
					end
					dcount_n = 2'd0;
					cnum_n   = 7'd0;
					if (c == irc_pkg::ChComma) begin
						bg_n = 1'b1;
					end else begin
						mode_n    = MODE_TEXT;
						bg_n      = 1'b0;
						run_plain = 1'b1;
					end
				end
			end
			default: begin
				mode_n    = MODE_TEXT;
				run_plain = 1'b1;
			end
		endcase
		if (run_plain) begin
			body_seg = plain_seg;
			bold_n   = p_bold;
			uline_n  = p_uline;
			rev_n    = p_rev;
			if (p_ctrl) begin
				mode_n = MODE_CTRL;
			end
		end
		// message end: a bare colour code still owes its reset
		if (in_item.message_last) begin
			if (mode_n == MODE_CTRL) begin
				suf_seg = irc_pkg::sgr_seg(irc_pkg::SgrNone, 1'b0);
			end
			mode_n   = MODE_TEXT;
			dcount_n = 2'd0;
			cnum_n   = 7'd0;
			bg_n     = 1'b0;
			bold_n   = 1'b0;
			uline_n  = 1'b0;
			rev_n    = 1'b0;
		end
	end

	// pack the three pieces into one byte run
	always_comb begin
		logic [irc_pkg::RunW-1:0] plen, pblen, pos;
		plen  = irc_pkg::RunW'(pre_seg.len);
		pblen = plen + irc_pkg::RunW'(body_seg.len);
		q_cmd.len = pblen + irc_pkg::RunW'(suf_seg.len);
		for (int i = 0; i < irc_pkg::MaxRun; i++) begin
			pos = irc_pkg::RunW'(i);
			if (pos < plen) begin
				q_cmd.b[i] = pre_seg.b[pos[irc_pkg::SegW-1:0]];
			end else if (pos < pblen) begin
				q_cmd.b[i] = body_seg.b[irc_pkg::SegW'(pos - plen)];
			end else begin
				q_cmd.b[i] = suf_seg.b[irc_pkg::SegW'(pos - pblen)];
			end
		end
	end

	assign q_push = take && (q_cmd.len != '0);

	// parse state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_TEXT;
			dcount_q <= 2'd0;
			cnum_q   <= 7'd0;
			bg_q     <= 1'b0;
			bold_q   <= 1'b0;
			uline_q  <= 1'b0;
			rev_q    <= 1'b0;
			filter_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				filter_q <= cfg_filter;
			end
			if (take) begin
				mode_q   <= mode_n;
				dcount_q <= dcount_n;
				cnum_q   <= cnum_n;
				bg_q     <= bg_n;
				bold_q   <= bold_n;
				uline_q  <= uline_n;
				rev_q    <= rev_n;
			end
		end
	end

	// a colour number never holds more than two digits
	assert property (@(posedge clk) disable iff (!arst_n) dcount_q != 2'd3)
		else $error("digit count overflow");

endmodule

`default_nettype wire

// ----- rtl/irc_cmdq.sv -----
`default_nettype none

module irc_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire irc_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output irc_pkg::cmd_t      head,
	output logic               head_valid
);

	irc_pkg::cmd_t              entries_q [irc_pkg::QDepth];
	logic [irc_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [irc_pkg::QCntW-1:0]  count_q;

	assign full       = (count_q == irc_pkg::QCntW'(irc_pkg::QDepth));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	// storage, written on a push
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("push into a full command queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from an empty command queue");

endmodule

`default_nettype wire

// ----- rtl/irc_back.sv -----
`default_nettype none

module irc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire irc_pkg::cmd_t  head,
	input  wire logic           head_valid,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output irc_pkg::out_item_t  out_item
);

	logic [irc_pkg::RunW-1:0] idx_q;
	logic                     out_valid_q;
	irc_pkg::out_item_t       out_q;
	logic                     load;
	logic                     at_end;

	assign load      = !out_valid_q || out_ready;
	assign at_end    = (idx_q == head.len - 1'b1);
	assign pop       = load && head_valid && at_end;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// output register, refilled as each transfer completes
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q.out_byte <= head.b[idx_q];
			out_q.run_last <= at_end;
		end
	end

	// byte index within the run and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= at_end ? '0 : idx_q + 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) head_valid |-> head.len != '0)
		else $error("empty run queued");
	assert property (@(posedge clk) disable iff (!arst_n) head_valid |-> idx_q < head.len)
		else $error("byte index past end of run");

endmodule

`default_nettype wire
